FILE: rtl/core/lcs_pkg.sv
// Shared types, widths and constants of the line centroid steering block.
package lcs_pkg;

    localparam int NUM_SENSORS = 8;
    localparam int SAMPLE_BITS = 10;

    localparam int THRESH_BITS = 10;
    localparam int SPEED_BITS  = 8;
    localparam int GAIN_BITS   = 10;
    localparam int CFG_DATA_BITS = 10;
    localparam int CFG_INDEX_BITS = 2;

    localparam int IDX_BITS  = $clog2(NUM_SENSORS);
    localparam int CMP_BITS  = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
    localparam int WT_BITS   = SAMPLE_BITS + IDX_BITS;
    localparam int WSUM_BITS = SAMPLE_BITS + 2 * IDX_BITS;
    localparam int TOT_BITS  = SAMPLE_BITS + IDX_BITS;
    localparam int NUM_BITS  = SAMPLE_BITS + 2 * IDX_BITS + 2;
    localparam int DEN_BITS  = TOT_BITS + 1;

    localparam int MAG_MAX  = (NUM_SENSORS - 1) / 2;
    localparam int MAG_BITS = (MAG_MAX > 0) ? $clog2(MAG_MAX + 1) : 1;
    localparam int REM_BITS = MAG_BITS + 1;

    localparam int ERR_BITS   = 5;
    localparam int DELTA_BITS = ERR_BITS + GAIN_BITS + 1;
    localparam int SUM_BITS   = DELTA_BITS + 1;

    localparam logic signed [ERR_BITS-1:0] LOST_ERR = ERR_BITS'(10);

    localparam logic [THRESH_BITS-1:0] DARK_THRESHOLD_RST = THRESH_BITS'(515);
    localparam logic [SPEED_BITS-1:0]  CRUISE_SPEED_RST   = SPEED_BITS'(220);
    localparam logic [GAIN_BITS-1:0]   STEER_GAIN_RST     = GAIN_BITS'(295);
    localparam logic [SPEED_BITS-1:0]  SPEED_LIMIT_RST    = SPEED_BITS'(220);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DARK_THRESHOLD = 2'd0,
        REG_CRUISE_SPEED   = 2'd1,
        REG_STEER_GAIN     = 2'd2,
        REG_SPEED_LIMIT    = 2'd3
    } cfg_reg_e;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t sample_0;
        sample_t sample_1;
        sample_t sample_2;
        sample_t sample_3;
        sample_t sample_4;
        sample_t sample_5;
        sample_t sample_6;
        sample_t sample_7;
    } in_item_t;

    typedef struct packed {
        logic signed [ERR_BITS-1:0] line_error;
        logic                       line_found;
        logic [SPEED_BITS-1:0]      left_drive;
        logic [SPEED_BITS-1:0]      right_drive;
    } out_item_t;

    typedef struct packed {
        logic                 seen;
        logic [SAMPLE_BITS-1:0] value;
        logic [WT_BITS-1:0]   weighted;
    } lane_out_t;

    typedef struct packed {
        logic                 found;
        logic [WSUM_BITS-1:0] wsum;
        logic [TOT_BITS-1:0]  total;
    } merge_out_t;

    typedef struct packed {
        logic                       found;
        logic signed [ERR_BITS-1:0] err;
    } err_out_t;

    typedef struct packed {
        logic load_prod;
        logic load_out;
    } drive_ctl_t;

endpackage

FILE: rtl/core/lcs_lane.sv
// One sensor lane: threshold test and index weighting of a single sample.
module lcs_lane (
    input  logic                          clk,
    input  logic                          load,
    input  logic [lcs_pkg::IDX_BITS-1:0]    lane_idx,
    input  lcs_pkg::sample_t              sample,
    input  logic [lcs_pkg::THRESH_BITS-1:0] threshold,
    output lcs_pkg::lane_out_t            lane_out
);
    import lcs_pkg::*;

    lane_out_t lane_reg;
    lane_out_t lane_next;
    logic      seen;

    always_comb
    begin
        seen = CMP_BITS'(sample) > CMP_BITS'(threshold);
        lane_next.seen     = seen;
        lane_next.value    = seen ? sample : '0;
        lane_next.weighted = seen ? WT_BITS'(WT_BITS'(lane_idx) * WT_BITS'(sample)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

    // Samples at or below the threshold contribute nothing.
    a_lane_dark: assert property (@(posedge clk)
        load && !seen |=> !lane_reg.seen && lane_reg.value == '0 && lane_reg.weighted == '0)
        else $error("dark sample leaked into lane sums");

endmodule

FILE: rtl/core/lcs_merge.sv
// Merge stage: sums lane contributions into weighted sum, total and found flag.
module lcs_merge (
    input  logic                 clk,
    input  logic                 load,
    input  lcs_pkg::lane_out_t   lanes [lcs_pkg::NUM_SENSORS],
    output lcs_pkg::merge_out_t  merge_out
);
    import lcs_pkg::*;

    merge_out_t merge_reg;
    merge_out_t merge_next;

    always_comb
    begin
        merge_next = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            merge_next.found = merge_next.found | lanes[i].seen;
            merge_next.wsum  = merge_next.wsum + WSUM_BITS'(lanes[i].weighted);
            merge_next.total = merge_next.total + TOT_BITS'(lanes[i].value);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            merge_reg <= merge_next;
        end
    end

    assign merge_out = merge_reg;

endmodule

FILE: rtl/core/lcs_error.sv
// Error stage: truncated centroid offset by parallel compares, lost-line handling.
module lcs_error (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  lcs_pkg::merge_out_t  merge_in,
    output lcs_pkg::err_out_t    err_out
);
    import lcs_pkg::*;

    err_out_t                   err_reg;
    err_out_t                   err_next;
    logic signed [REM_BITS-1:0] rem_reg;
    logic signed [REM_BITS-1:0] rem_next;
    logic [NUM_BITS-1:0]        num;
    logic [NUM_BITS-1:0]        abs_num;
    logic [DEN_BITS-1:0]        den;
    logic [MAG_BITS-1:0]        mag;
    logic                       neg;

    always_comb
    begin
        // num = 2W - (N-1)T, den = 2T; the quotient is at most MAG_MAX
        num     = (NUM_BITS'(merge_in.wsum) << 1)
                - NUM_BITS'(NUM_SENSORS - 1) * NUM_BITS'(merge_in.total);
        neg     = num[NUM_BITS-1];
        abs_num = neg ? (~num + NUM_BITS'(1)) : num;
        den     = {merge_in.total, 1'b0};
        mag     = '0;
        for (int k = 1; k <= MAG_MAX; k++)
        begin
            if (abs_num >= NUM_BITS'(k) * NUM_BITS'(den))
            begin
                mag = MAG_BITS'(k);
            end
        end

        rem_next       = rem_reg;
        err_next.found = merge_in.found;
        if (merge_in.found)
        begin
            rem_next     = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            err_next.err = ERR_BITS'(rem_next);
        end
        else if (rem_reg > 0)
        begin
            err_next.err = -LOST_ERR;
        end
        else if (rem_reg < 0)
        begin
            err_next.err = LOST_ERR;
        end
        else
        begin
            err_next.err = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (load)
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg <= err_next;
        end
    end

    assign err_out = err_reg;

    // A lost line leaves the remembered error untouched.
    a_rem_hold: assert property (@(posedge clk) disable iff (!rst_n)
        load && !merge_in.found |=> $stable(rem_reg))
        else $error("remembered error changed on a lost line");

    // On line, the error stays within the centroid range.
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        load && merge_in.found |=> err_reg.found
            && err_reg.err <= ERR_BITS'(MAG_MAX) && err_reg.err >= -ERR_BITS'(MAG_MAX))
        else $error("on-line error out of range");

endmodule

FILE: rtl/core/lcs_drive.sv
// Drive stages: error times gain, then base plus/minus offset saturated to 0..limit.
module lcs_drive (
    input  logic                             clk,
    input  lcs_pkg::drive_ctl_t              ctl,
    input  lcs_pkg::err_out_t                err_in,
    input  logic [lcs_pkg::SPEED_BITS-1:0]   cruise_speed,
    input  logic [lcs_pkg::GAIN_BITS-1:0]    steer_gain,
    input  logic [lcs_pkg::SPEED_BITS-1:0]   speed_limit,
    output lcs_pkg::out_item_t               out_item
);
    import lcs_pkg::*;

    err_out_t                     prod_err_reg;
    logic signed [DELTA_BITS-1:0] delta_reg;
    logic signed [DELTA_BITS-1:0] delta_next;
    out_item_t                    out_reg;
    out_item_t                    out_next;
    logic signed [SUM_BITS-1:0]   base_ext;
    logic signed [SUM_BITS-1:0]   left_sum;
    logic signed [SUM_BITS-1:0]   right_sum;

    function automatic logic [SPEED_BITS-1:0] clamp_drive(
        input logic signed [SUM_BITS-1:0] v,
        input logic [SPEED_BITS-1:0]      lim
    );
        logic [SPEED_BITS-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed({{(SUM_BITS-SPEED_BITS){1'b0}}, lim}))
        begin
            r = lim;
        end
        else
        begin
            r = v[SPEED_BITS-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        delta_next = err_in.err * $signed({1'b0, steer_gain});
        base_ext   = $signed({{(SUM_BITS-SPEED_BITS){1'b0}}, cruise_speed});
        left_sum   = base_ext - SUM_BITS'(delta_reg);
        right_sum  = base_ext + SUM_BITS'(delta_reg);
        out_next.line_error  = prod_err_reg.err;
        out_next.line_found  = prod_err_reg.found;
        out_next.left_drive  = clamp_drive(left_sum, speed_limit);
        out_next.right_drive = clamp_drive(right_sum, speed_limit);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_prod)
        begin
            prod_err_reg <= err_in;
            delta_reg    <= delta_next;
        end
        if (ctl.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign out_item = out_reg;

    a_left_sat: assert property (@(posedge clk)
        ctl.load_out |=> out_reg.left_drive <= speed_limit)
        else $error("left drive above limit");

    a_right_sat: assert property (@(posedge clk)
        ctl.load_out |=> out_reg.right_drive <= speed_limit)
        else $error("right drive above limit");

endmodule

FILE: rtl/core/line_centroid_steering.sv
// Top level of the line centroid steering block: config registers and pipeline control.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one transaction carries eight sensor
//     samples. out channel (out_valid/out_ready/out_data): one transaction per
//     input, carrying line error, found flag and left/right wheel drive.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is always
//     high; index 0 threshold, 1 cruise speed, 2 gain, 3 speed limit. Write only
//     while no transaction is in flight.
// Pipeline: lanes (threshold and weight, one per sensor), merge (sums), error
//   (centroid compare against 1x..3x the denominator, remembered error), gain
//   product, saturation into the output register.
// Path: an accepted item crosses the lane, merge, error, product and output registers.
// Throughput: one transaction per cycle while out_ready stays high; the remembered
//   error is read and written in the error stage, so back-to-back items see it in order.
// Stall: while out_ready is low the output register holds; the stages behind
//   it keep filling, and in_ready drops once the first stage can not advance.
// Reset: clears the stage valid bits, the remembered error (to 0) and loads
//   the register defaults 515, 220, 295, 220. No clearing pass is needed.
module line_centroid_steering (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  lcs_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output lcs_pkg::out_item_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lcs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lcs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import lcs_pkg::*;

    logic [THRESH_BITS-1:0] dark_threshold_reg;
    logic [SPEED_BITS-1:0]  cruise_speed_reg;
    logic [GAIN_BITS-1:0]   steer_gain_reg;
    logic [SPEED_BITS-1:0]  speed_limit_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic load1, load2, load3, load4, load_out;
    logic free1, free2, free3, free4, free_out;

    sample_t    samples [NUM_SENSORS];
    lane_out_t  lanes   [NUM_SENSORS];
    merge_out_t merge_q;
    err_out_t   err_q;
    drive_ctl_t drive_ctl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_threshold_reg <= DARK_THRESHOLD_RST;
            cruise_speed_reg   <= CRUISE_SPEED_RST;
            steer_gain_reg     <= STEER_GAIN_RST;
            speed_limit_reg    <= SPEED_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_DARK_THRESHOLD: dark_threshold_reg <= cfg_data[THRESH_BITS-1:0];
                REG_CRUISE_SPEED:   cruise_speed_reg   <= cfg_data[SPEED_BITS-1:0];
                REG_STEER_GAIN:     steer_gain_reg     <= cfg_data[GAIN_BITS-1:0];
                REG_SPEED_LIMIT:    speed_limit_reg    <= cfg_data[SPEED_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Advance a stage when the one ahead is empty or moving on.
    always_comb
    begin
        free_out = !out_valid_reg || out_ready;
        load_out = s4_valid_reg && free_out;
        free4    = !s4_valid_reg || load_out;
        load4    = s3_valid_reg && free4;
        free3    = !s3_valid_reg || load4;
        load3    = s2_valid_reg && free3;
        free2    = !s2_valid_reg || load3;
        load2    = s1_valid_reg && free2;
        free1    = !s1_valid_reg || load2;
        load1    = in_valid && free1;
    end

    assign in_ready  = free1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= load1 || (s1_valid_reg && !load2);
            s2_valid_reg  <= load2 || (s2_valid_reg && !load3);
            s3_valid_reg  <= load3 || (s3_valid_reg && !load4);
            s4_valid_reg  <= load4 || (s4_valid_reg && !load_out);
            out_valid_reg <= load_out || (out_valid_reg && !out_ready);
        end
    end

    assign samples[0] = in_data.sample_0;
    assign samples[1] = in_data.sample_1;
    assign samples[2] = in_data.sample_2;
    assign samples[3] = in_data.sample_3;
    assign samples[4] = in_data.sample_4;
    assign samples[5] = in_data.sample_5;
    assign samples[6] = in_data.sample_6;
    assign samples[7] = in_data.sample_7;

    for (genvar i = 0; i < NUM_SENSORS; i++)
    begin : g_lane
        lcs_lane u_lane (
            .clk       (clk),
            .load      (load1),
            .lane_idx  (IDX_BITS'(i)),
            .sample    (samples[i]),
            .threshold (dark_threshold_reg),
            .lane_out  (lanes[i])
        );
    end

    lcs_merge u_merge (
        .clk       (clk),
        .load      (load2),
        .lanes     (lanes),
        .merge_out (merge_q)
    );

    lcs_error u_error (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load3),
        .merge_in (merge_q),
        .err_out  (err_q)
    );

    assign drive_ctl.load_prod = load4;
    assign drive_ctl.load_out  = load_out;

    lcs_drive u_drive (
        .clk          (clk),
        .ctl          (drive_ctl),
        .err_in       (err_q),
        .cruise_speed (cruise_speed_reg),
        .steer_gain   (steer_gain_reg),
        .speed_limit  (speed_limit_reg),
        .out_item     (out_data)
    );

endmodule

FILE: test/line_centroid_steering_check.sv
// Checker for the line centroid steering block: predicts each wheel drive result and compares.
module line_centroid_steering_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  lcs_pkg::in_item_t                   in_data,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  lcs_pkg::out_item_t                  out_data,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [lcs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lcs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output int                                  mismatches,
    output int                                  drives_owed
);
    import lcs_pkg::*;

    int        dark_level;
    int        cruise;
    int        gain;
    int        ceiling;
    int        held_err;
    out_item_t drive_due [$];
    out_item_t want;

    task automatic flag_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic logic [SPEED_BITS-1:0] clamp_drive(input int level);
        if (level < 0)
            return '0;
        if (level > ceiling)
            return SPEED_BITS'(ceiling);
        return SPEED_BITS'(level);
    endfunction

    // Weighted centroid of the sensors above the dark level, steered into two wheel drives.
    function automatic out_item_t centroid_steer(input in_item_t s);
        sample_t   smp [NUM_SENSORS];
        int        wsum;
        int        total;
        int        num;
        int        mag;
        int        err;
        int        delta;
        logic      found;
        out_item_t r;
        smp = '{s.sample_0, s.sample_1, s.sample_2, s.sample_3,
                s.sample_4, s.sample_5, s.sample_6, s.sample_7};
        wsum = 0;
        total = 0;
        found = 1'b0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            if (int'(smp[i]) > dark_level)
            begin
                wsum += i * int'(smp[i]);
                total += int'(smp[i]);
                found = 1'b1;
            end
        end
        if (found)
        begin
            // truncate (W/T - 3.5) toward zero in exact integers
            num = 2 * wsum - (NUM_SENSORS - 1) * total;
            mag = (num < 0 ? -num : num) / (2 * total);
            err = (num < 0) ? -mag : mag;
            held_err = err;
        end
        else if (held_err > 0)
            err = -10;
        else if (held_err < 0)
            err = 10;
        else
            err = 0;
        delta = err * gain;
        r.line_error = ERR_BITS'(err);
        r.line_found = found;
        r.left_drive = clamp_drive(cruise - delta);
        r.right_drive = clamp_drive(cruise + delta);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_level = int'(DARK_THRESHOLD_RST);
            cruise = int'(CRUISE_SPEED_RST);
            gain = int'(STEER_GAIN_RST);
            ceiling = int'(SPEED_LIMIT_RST);
            held_err = 0;
            drive_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_e'(cfg_index))
                    REG_DARK_THRESHOLD: dark_level = int'(cfg_data[THRESH_BITS-1:0]);
                    REG_CRUISE_SPEED:   cruise = int'(cfg_data[SPEED_BITS-1:0]);
                    REG_STEER_GAIN:     gain = int'(cfg_data[GAIN_BITS-1:0]);
                    REG_SPEED_LIMIT:    ceiling = int'(cfg_data[SPEED_BITS-1:0]);
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                drive_due.push_back(centroid_steer(in_data));
            if (out_valid && out_ready)
            begin
                if (drive_due.size() == 0)
                    flag_mismatch($sformatf("result with nothing expected: err %0d drives %0d/%0d",
                                            $signed(out_data.line_error), out_data.left_drive,
                                            out_data.right_drive));
                else
                begin
                    want = drive_due.pop_front();
                    if (out_data.line_error !== want.line_error)
                        flag_mismatch($sformatf("line_error got %0d want %0d",
                                                $signed(out_data.line_error),
                                                $signed(want.line_error)));
                    if (out_data.line_found !== want.line_found)
                        flag_mismatch($sformatf("line_found got %0b want %0b",
                                                out_data.line_found, want.line_found));
                    if (out_data.left_drive !== want.left_drive)
                        flag_mismatch($sformatf("left_drive got %0d want %0d",
                                                out_data.left_drive, want.left_drive));
                    if (out_data.right_drive !== want.right_drive)
                        flag_mismatch($sformatf("right_drive got %0d want %0d",
                                                out_data.right_drive, want.right_drive));
                end
            end
        end
        drives_owed = drive_due.size();
    end

endmodule

FILE: test/line_centroid_steering_tb.sv
// Testbench top for the line centroid steering block: stimulus, stalls and verdict.
module line_centroid_steering_tb;
    import lcs_pkg::*;

    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 138;
    localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    in_item_t                 in_data = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    out_item_t                out_data;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    cfg_reg_e                 cfg_index = REG_DARK_THRESHOLD;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    logic calm = 1'b0;
    int   ready_left = 0;
    int   idle_cycles = 0;
    int   dark_now = int'(DARK_THRESHOLD_RST);
    int   fail_count;
    int   drives_owed;

    line_centroid_steering dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    line_centroid_steering_check check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (fail_count),
        .drives_owed (drives_owed)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones; none at all in a calm phase.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    always @(posedge clk)
    begin
        if (ready_left > 0)
            ready_left <= ready_left - 1;
        else if (calm || !out_ready)
        begin
            out_ready <= 1'b1;
            ready_left <= $urandom_range(24, 1);
        end
        else
        begin
            out_ready <= 1'b0;
            ready_left <= pick_gap();
        end
    end

    // End the run if no transaction moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("line_centroid_steering test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic in_item_t samples_of(input int v0, input int v1, input int v2,
                                            input int v3, input int v4, input int v5,
                                            input int v6, input int v7);
        in_item_t r;
        r.sample_0 = SAMPLE_BITS'(v0);
        r.sample_1 = SAMPLE_BITS'(v1);
        r.sample_2 = SAMPLE_BITS'(v2);
        r.sample_3 = SAMPLE_BITS'(v3);
        r.sample_4 = SAMPLE_BITS'(v4);
        r.sample_5 = SAMPLE_BITS'(v5);
        r.sample_6 = SAMPLE_BITS'(v6);
        r.sample_7 = SAMPLE_BITS'(v7);
        return r;
    endfunction

    function automatic int bright_sample();
        int r;
        r = $urandom_range(99);
        if (dark_now >= SAMPLE_MAX || r < 10)
            return SAMPLE_MAX;
        if (r < 20)
            return dark_now + 1;
        return $urandom_range(SAMPLE_MAX, dark_now + 1);
    endfunction

    function automatic int dark_sample();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return dark_now;
        if (r < 20)
            return 0;
        return $urandom_range(dark_now, 0);
    endfunction

    // Mostly a line under one to three adjacent sensors; the rest lost, scattered or raw noise.
    function automatic in_item_t random_samples();
        int v [NUM_SENSORS];
        int r;
        int center;
        int width;
        r = $urandom_range(99);
        center = $urandom_range(NUM_SENSORS - 1, 0);
        width = $urandom_range(3, 1);
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            if (r < 65)
                v[i] = (i >= center && i < center + width) ? bright_sample() : dark_sample();
            else if (r < 80)
                v[i] = dark_sample();
            else if (r < 92)
                v[i] = $urandom_range(1) ? bright_sample() : dark_sample();
            else
                v[i] = $urandom_range(SAMPLE_MAX, 0);
        end
        return samples_of(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endfunction

    task automatic send_samples(input in_item_t d, input int gap);
        logic took;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= d;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input int value);
        logic took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_BITS'(value);
        do
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    // Eight-bit registers get random junk in the upper data bits, which must be dropped.
    task automatic apply_settings(input int dark, input int base, input int gain, input int lim);
        write_reg(REG_DARK_THRESHOLD, dark);
        write_reg(REG_CRUISE_SPEED, ($urandom_range(3) << SPEED_BITS) | base);
        write_reg(REG_STEER_GAIN, gain);
        write_reg(REG_SPEED_LIMIT, ($urandom_range(3) << SPEED_BITS) | lim);
        cfg_valid <= 1'b0;
        dark_now = dark;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (drives_owed != 0);
        @(posedge clk);
    endtask

    initial
    begin
        int dark;
        int base;
        int gain;
        int lim;
        int count;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: extremes, single sensors other than 3, exact halves, lost after each sign
        send_samples(samples_of(0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_samples(samples_of(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023), pick_gap());
        send_samples(samples_of(1023, 0, 0, 0, 0, 0, 0, 0), pick_gap());
        send_samples(samples_of(0, 0, 0, 0, 0, 0, 0, 0), pick_gap());
        send_samples(samples_of(0, 0, 0, 0, 0, 0, 0, 516), pick_gap());
        send_samples(samples_of(0, 0, 0, 0, 0, 0, 0, 0), pick_gap());
        send_samples(samples_of(0, 0, 0, 0, 0, 0, 800, 800), pick_gap());
        send_samples(samples_of(600, 600, 0, 0, 0, 0, 0, 0), pick_gap());
        send_samples(samples_of(515, 515, 515, 515, 515, 515, 515, 515), pick_gap());
        send_samples(samples_of(0, 0, 0, 0, 700, 0, 0, 0), pick_gap());
        send_samples(samples_of(0, 0, 0, 0, 0, 0, 0, 0), pick_gap());
        send_samples(samples_of(0, 1023, 0, 0, 0, 0, 0, 0), pick_gap());
        send_samples(samples_of(0, 0, 900, 0, 0, 0, 0, 0), pick_gap());
        send_samples(samples_of(0, 0, 0, 0, 0, 520, 0, 0), pick_gap());
        send_samples(samples_of(0, 0, 0, 0, 0, 0, 1000, 0), pick_gap());
        send_samples(samples_of(682, 341, 682, 341, 682, 341, 682, 341), pick_gap());
        send_samples(samples_of(341, 682, 341, 682, 341, 682, 341, 682), pick_gap());
        in_valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    dark = 0; base = 255; gain = 1023; lim = 255;
                end
                1:
                begin
                    dark = 1023; base = 0; gain = 0; lim = 0;
                end
                2:
                begin
                    dark = 100; base = 200; gain = 1; lim = 150;
                end
                3:
                begin
                    dark = 900; base = 128; gain = 40; lim = 255;
                end
                4:
                begin
                    dark = 515; base = 220; gain = 295; lim = 220;
                end
                default:
                begin
                    dark = $urandom_range(950, 50);
                    base = $urandom_range(255, 0);
                    gain = $urandom_range(3) == 0 ? $urandom_range(1023, 0) : $urandom_range(80, 0);
                    lim = $urandom_range(255, 0);
                end
            endcase
            calm <= ($urandom_range(3) == 0);
            apply_settings(dark, base, gain, lim);
            // nothing can cross the top threshold, so keep that phase short
            count = (p == 1) ? 30 : ITEMS_PER_PHASE;
            for (int k = 0; k < count; k++)
                send_samples(random_samples(), pick_gap());
            in_valid <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && drives_owed == 0)
            $display("line_centroid_steering test passed");
        else
            $display("line_centroid_steering test failed");
        $finish;
    end

endmodule
